// ===== hdl/tsqpm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the timestamp queue position match block.
// Used by the channel interfaces and every module in hdl/.
package tsqpm_pkg;

    // Field widths fixed by the command and result formats
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned ENTRIES_W = 7;
    localparam int unsigned CFG_IDX_W = 2;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE    = 2'd3;

    // Timestamp reported when nothing matched
    localparam logic signed [WORD_W-1:0] STAMP_NONE = -32'sd1;

    // Configuration state seen by the back end
    typedef struct packed {
        logic                 present;
        logic [ENTRIES_W-1:0] entries;
        logic [WORD_W-1:0]    ring_offset;
        logic [WORD_W-1:0]    ring_size;
        logic                 clear;     // queue_entries written this cycle
    } cfg_t;

    // Classified command passed from front to back
    // fin: span end (position + length) on a write, ring end on a read
    typedef struct packed {
        logic                     command;
        logic signed [WORD_W-1:0] stamp;
        logic [WORD_W-1:0]        position;
        logic [WORD_W-1:0]        span_length;
        logic [WORD_W-1:0]        fin;
    } cmd_t;

    // One stored queue entry, with its precomputed span end
    typedef struct packed {
        logic signed [WORD_W-1:0] stamp;
        logic [WORD_W-1:0]        position;
        logic [WORD_W-1:0]        span_length;
        logic [WORD_W-1:0]        span_end;
    } entry_t;

endpackage

// ===== hdl/tsqpm_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: command words in, result words out, config writes.
// Depends on tsqpm_pkg for field widths.
interface tsqpm_in_if;
    logic                               valid;
    logic                               ready;
    logic                               command;
    logic signed [tsqpm_pkg::WORD_W-1:0] stamp;
    logic [tsqpm_pkg::WORD_W-1:0]       position;
    logic [tsqpm_pkg::WORD_W-1:0]       span_length;

    modport source (output valid, command, stamp, position, span_length, input ready);
    modport sink   (input valid, command, stamp, position, span_length, output ready);
endinterface

interface tsqpm_out_if;
    logic                               valid;
    logic                               ready;
    logic                               found;
    logic signed [tsqpm_pkg::WORD_W-1:0] result_stamp;
    logic [tsqpm_pkg::WORD_W-1:0]       result_position;
    logic [tsqpm_pkg::WORD_W-1:0]       result_length;
    logic                               queue_full;
    logic                               overflow_error;

    modport source (output valid, found, result_stamp, result_position, result_length,
                     queue_full, overflow_error, input ready);
    modport sink   (input valid, found, result_stamp, result_position, result_length,
                    queue_full, overflow_error, output ready);
endinterface

interface tsqpm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [tsqpm_pkg::CFG_IDX_W-1:0]    index;
    logic [tsqpm_pkg::WORD_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/tsqpm_front.sv =====
`timescale 1ns / 1ps
// Front end: configuration registers, command intake and classification.
// Depends on tsqpm_pkg and the channel interfaces in tsqpm_if.sv.
module tsqpm_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    tsqpm_cfg_if.sink             cfg,
    tsqpm_in_if.sink              request,
    input  logic                  q_ready,
    output logic                  q_push,
    output tsqpm_pkg::cmd_t       q_word,
    output tsqpm_pkg::cfg_t       cfg_state
);

    logic                                present_reg;
    logic [tsqpm_pkg::ENTRIES_W-1:0]     entries_reg;
    logic [tsqpm_pkg::WORD_W-1:0]        offset_reg;
    logic [tsqpm_pkg::WORD_W-1:0]        size_reg;
    logic                                cfg_we;
    logic [tsqpm_pkg::WORD_W-1:0]        ring_end;
    logic [tsqpm_pkg::WORD_W-1:0]        pos_folded;

    // Config writes are always taken
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= 1'b0;
            entries_reg <= '0;
            offset_reg  <= '0;
            size_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg.index)
                tsqpm_pkg::CFG_PRESENT: present_reg <= cfg.data[0];
                tsqpm_pkg::CFG_ENTRIES: entries_reg <= cfg.data[tsqpm_pkg::ENTRIES_W-1:0];
                tsqpm_pkg::CFG_OFFSET:  offset_reg  <= cfg.data;
                tsqpm_pkg::CFG_SIZE:    size_reg    <= cfg.data;
                default:                present_reg <= present_reg;
            endcase
        end
    end

    always_comb
    begin
        cfg_state.present     = present_reg;
        cfg_state.entries     = entries_reg;
        cfg_state.ring_offset = offset_reg;
        cfg_state.ring_size   = size_reg;
        cfg_state.clear       = cfg_we && (cfg.index == tsqpm_pkg::CFG_ENTRIES);
    end

    // Fold a read position once into the ring
    assign ring_end   = offset_reg + size_reg;
    assign pos_folded = (request.position >= ring_end) ? request.position - size_reg
                                                       : request.position;

    assign request.ready = q_ready;
    assign q_push        = request.valid && q_ready;

    // Classify: writes carry their span end, reads carry the ring end
    always_comb
    begin
        q_word.command     = request.command;
        q_word.stamp       = request.stamp;
        q_word.span_length = request.span_length;
        if (request.command == tsqpm_pkg::CMD_READ)
        begin
            q_word.position = pos_folded;
            q_word.fin      = ring_end;
        end
        else
        begin
            q_word.position = request.position;
            q_word.fin      = request.position + request.span_length;
        end
    end

endmodule

// ===== hdl/tsqpm_fifo.sv =====
`timescale 1ns / 1ps
// Two-word command queue between front and back end.
// Depends on tsqpm_pkg for the command word type.
module tsqpm_fifo
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tsqpm_pkg::cmd_t       wdata,
    output logic                  ready,
    input  logic                  pop,
    output logic                  valid,
    output tsqpm_pkg::cmd_t       rdata
);

    tsqpm_pkg::cmd_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;

    assign ready = (count_reg != 2'd2);
    assign valid = (count_reg != 2'd0);
    assign rdata = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== hdl/tsqpm_back.sv =====
`timescale 1ns / 1ps
// Back end: entry memory, head/tail/count, lookup scan and result register.
// Depends on tsqpm_pkg and the channel interfaces in tsqpm_if.sv.
module tsqpm_back
#(
    parameter int unsigned QUEUE_DEPTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tsqpm_pkg::cfg_t       cfg_state,
    input  logic                  q_valid,
    input  tsqpm_pkg::cmd_t       q_word,
    output logic                  q_pop,
    tsqpm_out_if.source           response
);

    localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned NUM_W = (CNT_W > tsqpm_pkg::ENTRIES_W) ? CNT_W
                                                                  : tsqpm_pkg::ENTRIES_W;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_CHECK = 1'b1;

    localparam int unsigned W = tsqpm_pkg::WORD_W;

    // Entry storage
    tsqpm_pkg::entry_t entry_mem [QUEUE_DEPTH];
    tsqpm_pkg::entry_t rdata_reg;
    tsqpm_pkg::entry_t wdata;
    logic              mem_we;
    logic              mem_re;
    logic [IDX_W-1:0]  rd_addr;

    // Queue and scan state
    logic              state_reg,    state_next;
    logic [IDX_W-1:0]  head_reg,     head_next;
    logic [IDX_W-1:0]  tail_reg,     tail_next;
    logic [CNT_W-1:0]  live_reg,     live_next;
    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic [W-1:0]      pos_reg,      pos_next;
    logic [W-1:0]      end_reg,      end_next;

    // Result register
    logic                 out_valid_reg, out_valid_next;
    logic                 found_reg,     found_next;
    logic signed [W-1:0]  stamp_reg,     stamp_next;
    logic [W-1:0]         rpos_reg,      rpos_next;
    logic [W-1:0]         rlen_reg,      rlen_next;
    logic                 full_reg,      full_next;
    logic                 ovf_reg,       ovf_next;
    logic                 out_load;
    logic                 out_free;

    logic [NUM_W-1:0]  num;
    logic              hit;
    logic [CNT_W-1:0]  live_left;

    // Advance an index round the usable part of the queue
    function automatic logic [IDX_W-1:0] fold_next(input logic [IDX_W-1:0] idx,
                                                  input logic [NUM_W-1:0] n);
        logic [NUM_W-1:0] inc;
        begin
            inc = NUM_W'(idx) + NUM_W'(1);
            if (inc >= n)
            begin
                inc = inc - n;
            end
            return inc[IDX_W-1:0];
        end
    endfunction

    // Usable entries, clamped to the storage depth
    assign num = (NUM_W'(cfg_state.entries) > NUM_W'(QUEUE_DEPTH)) ? NUM_W'(QUEUE_DEPTH)
                                                                   : NUM_W'(cfg_state.entries);

    // Span cover test on the fetched entry; spans past the ring end wrap to the offset
    always_comb
    begin
        if (rdata_reg.span_end <= end_reg)
        begin
            hit = (rdata_reg.position <= pos_reg) && (pos_reg < rdata_reg.span_end);
        end
        else
        begin
            hit = ((rdata_reg.position <= pos_reg) && (pos_reg < end_reg))
               || ((cfg_state.ring_offset <= pos_reg)
                   && (pos_reg < rdata_reg.span_end - cfg_state.ring_size));
        end
    end

    assign live_left = live_reg - scan_cnt_reg;
    assign out_free  = !out_valid_reg || response.ready;

    assign wdata.stamp       = q_word.stamp;
    assign wdata.position    = q_word.position;
    assign wdata.span_length = q_word.span_length;
    assign wdata.span_end    = q_word.fin;

    // Command sequencer
    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        live_next     = live_reg;
        scan_idx_next = scan_idx_reg;
        scan_cnt_next = scan_cnt_reg;
        pos_next      = pos_reg;
        end_next      = end_reg;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        rd_addr       = head_reg;
        out_load      = 1'b0;
        found_next    = 1'b0;
        stamp_next    = tsqpm_pkg::STAMP_NONE;
        rpos_next     = '0;
        rlen_next     = '0;
        full_next     = 1'b0;
        ovf_next      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    if (q_word.command == tsqpm_pkg::CMD_WRITE)
                    begin
                        out_load = 1'b1;
                        if (!q_word.stamp[W-1] && cfg_state.present)
                        begin
                            if (NUM_W'(live_reg) >= num)
                            begin
                                full_next = 1'b1;
                                ovf_next  = 1'b1;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                tail_next = fold_next(tail_reg, num);
                                live_next = live_reg + CNT_W'(1);
                                full_next = (NUM_W'(live_reg + CNT_W'(1)) >= num);
                            end
                        end
                    end
                    else if (!cfg_state.present)
                    begin
                        out_load = 1'b1;
                    end
                    else if (live_reg == '0)
                    begin
                        out_load  = 1'b1;
                        full_next = (NUM_W'(live_reg) >= num);
                    end
                    else
                    begin
                        // Start the scan at the head
                        mem_re        = 1'b1;
                        rd_addr       = head_reg;
                        scan_idx_next = head_reg;
                        scan_cnt_next = '0;
                        pos_next      = q_word.position;
                        end_next      = q_word.fin;
                        state_next    = ST_CHECK;
                    end
                end
            end

            ST_CHECK:
            begin
                if (hit)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        found_next = 1'b1;
                        stamp_next = rdata_reg.stamp;
                        rpos_next  = rdata_reg.position;
                        rlen_next  = rdata_reg.span_length;
                        head_next  = scan_idx_reg;
                        live_next  = live_left;
                        full_next  = (NUM_W'(live_left) >= num);
                        state_next = ST_IDLE;
                    end
                end
                else if (scan_cnt_reg + CNT_W'(1) == live_reg)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        full_next  = (NUM_W'(live_reg) >= num);
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    // Fetch the next live entry
                    mem_re        = 1'b1;
                    rd_addr       = fold_next(scan_idx_reg, num);
                    scan_idx_next = rd_addr;
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Writing the entry count empties the queue
        if (cfg_state.clear)
        begin
            head_next = '0;
            tail_next = '0;
            live_next = '0;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (response.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            live_reg      <= '0;
            scan_idx_reg  <= '0;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            live_reg      <= live_next;
            scan_idx_reg  <= scan_idx_next;
            scan_cnt_reg  <= scan_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Scan operands and result payload
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        end_reg <= end_next;
        if (out_load)
        begin
            found_reg <= found_next;
            stamp_reg <= stamp_next;
            rpos_reg  <= rpos_next;
            rlen_reg  <= rlen_next;
            full_reg  <= full_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[tail_reg] <= wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= entry_mem[rd_addr];
        end
    end

    assign response.valid           = out_valid_reg;
    assign response.found           = found_reg;
    assign response.result_stamp    = stamp_reg;
    assign response.result_position = rpos_reg;
    assign response.result_length   = rlen_reg;
    assign response.queue_full      = full_reg;
    assign response.overflow_error  = ovf_reg;

endmodule

// ===== hdl/timestamp_queue_position_match.sv =====
`timescale 1ns / 1ps
// Timestamp queue with ring-range lookup for one ring buffer.
//
// Channels: request takes command words (enqueue or look up), response returns
// one result word per command, cfg writes the four registers (present, entries,
// ring offset, ring size) and is always ready. Write cfg only while idle.
// An enqueue, or a lookup that needs no scan, passes from the command queue
// straight into the result register. A lookup that scans reads live entries from
// the head, one entry per cycle from the single read port of the entry memory,
// and returns at the first match or after the last live entry when none matches.
// Enqueues: one per cycle while response is ready; lookups run one at a time.
// A two-word queue between intake and the back end keeps request ready while a
// lookup scans, until it fills.
// Reset clears control, config, head, tail and count; entry memory, queue slots and result payload are not cleared.
// When response stalls, the result word holds and the back end waits; intake
// keeps taking words until its queue is full.
// Depends on tsqpm_pkg, tsqpm_if, tsqpm_front, tsqpm_fifo and tsqpm_back.
module timestamp_queue_position_match
#(
    parameter int unsigned QUEUE_DEPTH = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    tsqpm_cfg_if.sink     cfg,
    tsqpm_in_if.sink      request,
    tsqpm_out_if.source   response
);

    tsqpm_pkg::cfg_t cfg_state;
    tsqpm_pkg::cmd_t push_word;
    tsqpm_pkg::cmd_t pop_word;
    logic            push;
    logic            push_ready;
    logic            pop;
    logic            pop_valid;

    // Intake and classification
    tsqpm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .request   (request),
        .q_ready   (push_ready),
        .q_push    (push),
        .q_word    (push_word),
        .cfg_state (cfg_state)
    );

    // Command queue
    tsqpm_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_word),
        .ready (push_ready),
        .pop   (pop),
        .valid (pop_valid),
        .rdata (pop_word)
    );

    // Execution and results
    tsqpm_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_state (cfg_state),
        .q_valid   (pop_valid),
        .q_word    (pop_word),
        .q_pop     (pop),
        .response  (response)
    );

endmodule
